// ----- design/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue core.
// Used by spq_cell, sorted_priority_queue_core and the testbench; no other dependencies.
package spq_pkg;

   localparam int SPQ_DEPTH = 16;
   localparam int PRIO_W    = 16;
   localparam int ID_W      = 5;
   localparam int TAG_W     = 32;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE_HEAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_ID   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // One stored entry
   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [ID_W-1:0]          id;
      logic [TAG_W-1:0]         payload;
   } spq_entry_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic            go;        // commit the update this cycle
      logic            ins;       // insert decode
      logic            rem_head;  // remove-highest decode
      logic            rem_id;    // remove-by-id decode
      logic [ID_W-1:0] want;      // id searched by remove-by-id
      spq_entry_type   entry;     // entry to insert, id already assigned
   } spq_cmd_type;

endpackage

// ----- design/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_cmd_type  cmd,
   input  logic                  lft_valid,
   input  spq_pkg::spq_entry_type lft_entry,
   input  logic                  lft_mark,
   input  logic                  rgt_valid,
   input  spq_pkg::spq_entry_type rgt_entry,
   output logic                  valid,
   output spq_pkg::spq_entry_type entry,
   output logic                  mark,
   output logic                  hit
);
   import spq_pkg::*;

   logic          valid_ff, valid_in;
   spq_entry_type entry_ff, entry_in;
   logic          sel_here;

   // Does the operation start at or before this slot
   always_comb begin
      priority if (cmd.ins) begin
         sel_here = !valid_ff || (entry_ff.prio < cmd.entry.prio);
      end else if (cmd.rem_head) begin
         sel_here = 1'b1;
      end else if (cmd.rem_id) begin
         sel_here = valid_ff && (entry_ff.id == cmd.want);
      end else begin
         sel_here = 1'b0;
      end
   end

   assign mark = lft_mark | sel_here;
   assign hit  = sel_here & ~lft_mark;

   // Insert shifts toward the tail; removal pulls from the right
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.go) begin
         if (cmd.ins) begin
            if (lft_mark) begin
               valid_in = lft_valid;
               entry_in = lft_entry;
            end else if (sel_here) begin
               valid_in = 1'b1;
               entry_in = cmd.entry;
            end
         end else if (mark) begin
            valid_in = rgt_valid;
            entry_in = rgt_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ----- design/sorted_priority_queue_core.sv -----
// Top level of the sorted priority queue: a row of spq_cell slots plus response register.
// Depends on spq_pkg and spq_cell.
//
// The queue keeps up to DEPTH entries in descending priority order, equal
// priorities first in first out, in a row of slots that shift as a unit.
// It takes one request per clock and delivers its response in the
// following cycle from an output register; a request waits only while a
// response is held by rsp_stall. The cycle time is set by the ripple of
// the insert or remove position along the row of slots. An insert gets
// id count+1 (five bits, wrapping); remove-by-id deletes the first match
// from the head.
module sorted_priority_queue_core #(
   parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic [spq_pkg::ID_W-1:0]            req_target_id,
   input  logic [spq_pkg::TAG_W-1:0]           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [spq_pkg::ID_W-1:0]            rsp_entry_id,
   output logic signed [spq_pkg::PRIO_W-1:0]   rsp_entry_priority,
   output logic [spq_pkg::TAG_W-1:0]           rsp_entry_payload
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, accept, found;
   logic [ID_W-1:0]  new_id;
   spq_cmd_type      cmd;

   logic          cell_valid [DEPTH];
   spq_entry_type cell_entry [DEPTH];
   logic          cell_hit   [DEPTH];
   logic          lft_valid  [DEPTH];
   spq_entry_type lft_entry  [DEPTH];
   logic          rgt_valid  [DEPTH];
   spq_entry_type rgt_entry  [DEPTH];
   logic          mark_chain [DEPTH+1];
   spq_entry_type taken;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   spq_entry_type       out_ff, out_in;

   // Handshake: take a request unless a response is held
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign new_id = ID_W'(count_ff) + ID_W'(1);

   // Decode and broadcast the command
   always_comb begin
      cmd.ins           = (req_kind == KIND_INSERT);
      cmd.rem_head      = (req_kind == KIND_REMOVE_HEAD);
      cmd.rem_id        = (req_kind == KIND_REMOVE_ID);
      cmd.want          = req_target_id;
      cmd.entry.prio    = req_priority_req;
      cmd.entry.id      = new_id;
      cmd.entry.payload = req_payload;
      cmd.go            = accept && ((cmd.ins && !full) || (cmd.rem_head && !empty) ||
                                     cmd.rem_id);
   end

   assign mark_chain[0] = 1'b0;

   // Row of slots
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign lft_valid[g] = 1'b0;
         assign lft_entry[g] = cmd.entry;
      end else begin : g_body
         assign lft_valid[g] = cell_valid[g-1];
         assign lft_entry[g] = cell_entry[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign rgt_valid[g] = 1'b0;
         assign rgt_entry[g] = cell_entry[g];
      end else begin : g_mid
         assign rgt_valid[g] = cell_valid[g+1];
         assign rgt_entry[g] = cell_entry[g+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .lft_valid (lft_valid[g]),
         .lft_entry (lft_entry[g]),
         .lft_mark  (mark_chain[g]),
         .rgt_valid (rgt_valid[g]),
         .rgt_entry (rgt_entry[g]),
         .valid     (cell_valid[g]),
         .entry     (cell_entry[g]),
         .mark      (mark_chain[g+1]),
         .hit       (cell_hit[g])
      );
   end

   // Pick out the removed entry (at most one slot hits)
   always_comb begin
      taken = '0;
      found = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_hit[i]) begin
            taken = taken | cell_entry[i];
            found = 1'b1;
         end
      end
   end

   // Fill count and response contents
   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_MISS;
      out_in    = '0;
      if (cmd.ins) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_OK;
            out_in.id = new_id;
            count_in  = count_ff + CNT_W'(1);
         end
      end else if ((cmd.rem_head && !empty) || (cmd.rem_id && found)) begin
         status_in = STATUS_OK;
         out_in    = taken;
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_entry_id       = out_ff.id;
   assign rsp_entry_priority = out_ff.prio;
   assign rsp_entry_payload  = out_ff.payload;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for sorted_priority_queue_core: directed and random
// requests, with a local priority-queue predictor checking every response.
// Depends on spq_pkg and the RTL of the core.
`timescale 1ns / 100ps

module testbench;
   import spq_pkg::*;

   localparam int DEPTH = SPQ_DEPTH;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         payload;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = KIND_INSERT;
   logic signed [PRIO_W-1:0] req_priority_req = '0;
   logic [ID_W-1:0] req_target_id = '0;
   logic [TAG_W-1:0] req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0] rsp_entry_id;
   logic signed [PRIO_W-1:0] rsp_entry_priority;
   logic [TAG_W-1:0] rsp_entry_payload;

   // Predicted queue contents, head first
   spq_entry_type queue_slots[DEPTH];
   int queue_count = 0;

   response_type pending_responses[$];
   int requests_sent = 0;
   int responses_seen = 0;
   int error_count = 0;
   bit quiet_mode = 1'b0;
   int stall_left = 0;

   sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_priority_req(req_priority_req),
      .req_target_id(req_target_id),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_id(rsp_entry_id),
      .rsp_entry_priority(rsp_entry_priority),
      .rsp_entry_payload(rsp_entry_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly short, now and then long
   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // Take out the entry at pos, close the gap, and report it
   function automatic response_type take_entry(input int pos);
      response_type r;
      r.status  = STATUS_OK;
      r.id      = queue_slots[pos].id;
      r.prio    = queue_slots[pos].prio;
      r.payload = queue_slots[pos].payload;
      for (int i = pos; i + 1 < queue_count; i++)
         queue_slots[i] = queue_slots[i + 1];
      queue_count--;
      return r;
   endfunction

   // Apply one request to the predicted queue and return its response
   function automatic response_type apply_queue_op(input logic [KIND_W-1:0] kind,
                                                   input logic signed [PRIO_W-1:0] prio,
                                                   input logic [ID_W-1:0] want,
                                                   input logic [TAG_W-1:0] tag);
      response_type r;
      int pos;
      r = '{status: STATUS_MISS, id: '0, prio: '0, payload: '0};
      unique case (kind)
         KIND_INSERT: begin
            if (queue_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < queue_count && queue_slots[pos].prio >= prio)
                  pos++;
               for (int i = queue_count; i > pos; i--)
                  queue_slots[i] = queue_slots[i - 1];
               queue_slots[pos].prio    = prio;
               queue_slots[pos].id      = ID_W'(queue_count + 1);
               queue_slots[pos].payload = tag;
               queue_count++;
               r.status = STATUS_OK;
               r.id     = queue_slots[pos].id;
            end
         end
         KIND_REMOVE_HEAD: begin
            if (queue_count != 0)
               r = take_entry(0);
         end
         KIND_REMOVE_ID: begin
            for (int i = 0; i < queue_count; i++) begin
               if (queue_slots[i].id == want) begin
                  r = take_entry(i);
                  break;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
      error_count++;
   endtask

   // Response side back-pressure
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare responses first, then record the request taken at this edge
   always @(posedge clock) begin : check_responses
      response_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request pending", rsp_status, 0);
            end else begin
               exp_r = pending_responses.pop_front();
               if (rsp_status !== exp_r.status)
                  report_mismatch("status", rsp_status, exp_r.status);
               if (rsp_entry_id !== exp_r.id)
                  report_mismatch("entry_id", rsp_entry_id, exp_r.id);
               if (rsp_entry_priority !== exp_r.prio)
                  report_mismatch("entry_priority", rsp_entry_priority, exp_r.prio);
               if (rsp_entry_payload !== exp_r.payload)
                  report_mismatch("entry_payload", rsp_entry_payload, exp_r.payload);
               responses_seen++;
            end
         end
         if (req_valid && !req_stall)
            pending_responses.push_back(apply_queue_op(req_kind, req_priority_req,
                                                       req_target_id, req_payload));
      end
   end

   // Send one request after an optional gap; returns once it is accepted
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic signed [PRIO_W-1:0] prio,
                               input logic [ID_W-1:0] target,
                               input logic [TAG_W-1:0] tag);
      int gap;
      gap = (quiet_mode || $urandom_range(0, 9) < 6) ? 0 : pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_priority_req <= prio;
      req_target_id    <= target;
      req_payload      <= tag;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (responses_seen < requests_sent) @(posedge clock);
   endtask

   // Removals on an empty queue
   task automatic test_empty_queue();
      send_request(KIND_REMOVE_HEAD, '0, '0, '0);
      send_request(KIND_REMOVE_ID, '0, 5'd1, '0);
   endtask

   task automatic test_unused_kind();
      send_request(KIND_UNUSED, 16'sh7FFF, 5'd31, 32'hFFFF_FFFF);
   endtask

   // Fill with extreme and tied priorities, then one insert too many
   task automatic test_fill_to_full();
      logic signed [PRIO_W-1:0] prios[16] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                                              16'sh0001, 16'sh0000, 16'sh7FFF, -16'sh8000,
                                              16'sh0003, -16'sh0003, 16'sh0001, 16'sh1234,
                                              -16'sh1234, 16'sh0000, 16'sh7FFE, -16'sh7FFF};
      for (int i = 0; i < 16; i++)
         send_request(KIND_INSERT, prios[i], 5'd0,
                      (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
      send_request(KIND_INSERT, 16'sh0005, 5'd0, 32'hA5A5_5A5A);
   endtask

   // Hits and misses on remove-by-id, then a head removal
   task automatic test_removals();
      send_request(KIND_REMOVE_ID, '0, 5'd5, '0);
      send_request(KIND_REMOVE_ID, '0, 5'd31, '0);
      send_request(KIND_REMOVE_ID, '0, 5'd0, '0);
      send_request(KIND_REMOVE_HEAD, '0, '0, '0);
   endtask

   // Random traffic in blocks that lean toward filling, draining or balance
   task automatic test_random_traffic();
      int insert_pct;
      int roll;
      logic [KIND_W-1:0] kind;
      logic signed [PRIO_W-1:0] prio;
      logic [ID_W-1:0] target;
      for (int blk = 0; blk < 17; blk++) begin
         quiet_mode = (blk % 5 == 3);
         case (blk % 3)
            0: insert_pct = 75;
            1: insert_pct = 25;
            default: insert_pct = 50;
         endcase
         if (blk == 8)
            wait_until_drained();
         for (int n = 0; n < 52; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
               kind = KIND_UNUSED;
            else if (roll < 2 + insert_pct)
               kind = KIND_INSERT;
            else if ($urandom_range(0, 1) == 0)
               kind = KIND_REMOVE_HEAD;
            else
               kind = KIND_REMOVE_ID;
            roll = $urandom_range(0, 9);
            if (roll < 6)
               prio = PRIO_W'($signed($urandom_range(0, 8)) - 4);
            else if (roll < 9)
               prio = PRIO_W'($urandom);
            else
               prio = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            // Mostly ids that are present, otherwise any 5-bit value
            if (queue_count > 0 && $urandom_range(0, 3) != 0)
               target = queue_slots[$urandom_range(0, queue_count - 1)].id;
            else
               target = ID_W'($urandom_range(0, 31));
            send_request(kind, prio, target, $urandom);
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_unused_kind();
      test_fill_to_full();
      test_removals();
      wait_until_drained();
      test_random_traffic();
      wait_until_drained();
      repeat (8) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("responses never delivered", pending_responses.size(), 0);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_core.sv
tb/sv/testbench.sv
